/* rtl/wvsc_pkg.sv */
// ----------------------------------------------------------------------------
// wvsc_pkg
// Shared types and constants for the window variance stability check:
// transfer payloads, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package wvsc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int VAR_W     = 30;
    localparam int CNT_OUT_W = 9;
    localparam int QUO_W     = VAR_W + 1;
    localparam int DCNT_W    = $clog2(QUO_W + 1);

    localparam logic [VAR_W-1:0]  THRESHOLD_RESET = VAR_W'(100);
    localparam logic [VAR_W-1:0]  VAR_MAX         = {VAR_W{1'b1}};
    localparam logic [DCNT_W-1:0] DIV_STEPS       = DCNT_W'(QUO_W);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_item_t;

    typedef struct packed {
        logic [VAR_W-1:0]     window_variance;
        logic                 stable;
        logic [CNT_OUT_W-1:0] sample_count;
        logic                 truncated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_NSQ,
        ST_SSQ,
        ST_SUB,
        ST_NN,
        ST_DIV
    } seq_state_t;

endpackage

/* rtl/window_variance_stability_check_core.sv */
// ----------------------------------------------------------------------------
// Sequence: a sample with no last mark is taken, then squared by shift-add
// (one step per significant bit of |sample| plus one), and no new sample is
// taken until that is done. A last sample adds n*sumsq, sum^2, a subtract, n*n
// (one step per multiplier bit plus one each) and a 31-step restoring divide.
// Throughput is set by the single shift-add/subtract unit all steps share.
// Reset: control and accumulators cleared, threshold 100, no result pending.
// ----------------------------------------------------------------------------
// window_variance_stability_check_core
// Population variance of a flagged window of signed samples, with stable
// flag against a programmable threshold and a dropped-sample flag.
// ----------------------------------------------------------------------------
module window_variance_stability_check_core #(
    parameter int WINDOW_MAX = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  wvsc_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output wvsc_pkg::out_item_t         out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wvsc_pkg::VAR_W-1:0]  cfg_data
);
    import wvsc_pkg::*;

    localparam int LOG_W = $clog2(WINDOW_MAX);
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_W + 1 + LOG_W;
    localparam int SQ_W  = 2 * SAMPLE_W - 1 + LOG_W;
    localparam int MAG_W = SAMPLE_W + 1;
    localparam int PW    = 2 * SAMPLE_W + 2 * LOG_W;
    localparam int DSW   = 2 * CW + QUO_W - 1;
    localparam int XW    = (PW > DSW) ? PW : DSW;
    localparam int BW    = SUM_W;
    localparam logic [CW-1:0] WIN_MAX_C = CW'(WINDOW_MAX);

    seq_state_t             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]        sumsq_reg, sumsq_next;
    logic                   ovf_reg, ovf_next;
    logic                   last_reg, last_next;
    logic [VAR_W-1:0]       thr_reg, thr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;

    logic [XW-1:0]          mcand_reg, mcand_next;
    logic [BW-1:0]          mplier_reg, mplier_next;
    logic [XW-1:0]          prod_reg, prod_next;
    logic [XW-1:0]          t_reg, t_next;
    logic [XW-1:0]          rem_reg, rem_next;
    logic [XW-1:0]          dsh_reg, dsh_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    out_item_t              out_data_reg, out_data_next;

    logic [XW-1:0]          add_a, add_b;
    logic                   add_sub;
    logic [XW:0]            add_res;
    logic                   borrow;

    logic signed [MAG_W-1:0] samp_ext;
    logic [MAG_W-1:0]       samp_mag;
    logic [SUM_W-1:0]       sum_mag;
    logic [VAR_W-1:0]       var_sat;

    assign samp_ext = MAG_W'(in_data.sample);
    assign samp_mag = samp_ext[MAG_W-1] ? unsigned'(-samp_ext) : unsigned'(samp_ext);
    assign sum_mag  = sum_reg[SUM_W-1] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
    assign var_sat  = quo_reg[QUO_W-1] ? VAR_MAX : quo_reg[VAR_W-1:0];

    // shared add / subtract unit
    always_comb
    begin
        case (state_reg)
            ST_SUB:
            begin
                add_a   = t_reg;
                add_b   = prod_reg;
                add_sub = 1'b1;
            end
            ST_DIV:
            begin
                add_a   = rem_reg;
                add_b   = dsh_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_a   = prod_reg;
                add_b   = mplier_reg[0] ? mcand_reg : '0;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_res = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                             : ({1'b0, add_a} + {1'b0, add_b});
    assign borrow  = add_res[XW];

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        sumsq_next     = sumsq_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg;
        dcnt_next      = dcnt_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        prod_next      = prod_reg;
        t_next         = t_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid)
        begin
            thr_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = in_data.last;
                    if (count_reg < WIN_MAX_C)
                    begin
                        count_next  = count_reg + CW'(1);
                        sum_next    = sum_reg + SUM_W'(in_data.sample);
                        prod_next   = XW'(sumsq_reg);
                        mcand_next  = XW'(samp_mag);
                        mplier_next = BW'(samp_mag);
                        state_next  = ST_SQ;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (in_data.last)
                        begin
                            prod_next   = '0;
                            mcand_next  = XW'(sumsq_reg);
                            mplier_next = BW'(count_reg);
                            state_next  = ST_NSQ;
                        end
                    end
                end
            end
            ST_SQ, ST_NSQ, ST_SSQ, ST_NN:
            begin
                if (mplier_reg != '0)
                begin
                    prod_next   = add_res[XW-1:0];
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
                else
                begin
                    case (state_reg)
                        ST_SQ:
                        begin
                            sumsq_next = prod_reg[SQ_W-1:0];
                            if (last_reg)
                            begin
                                prod_next   = '0;
                                mcand_next  = XW'(prod_reg[SQ_W-1:0]);
                                mplier_next = BW'(count_reg);
                                state_next  = ST_NSQ;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        ST_NSQ:
                        begin
                            t_next      = prod_reg;
                            prod_next   = '0;
                            mcand_next  = XW'(sum_mag);
                            mplier_next = BW'(sum_mag);
                            state_next  = ST_SSQ;
                        end
                        ST_SSQ:
                        begin
                            state_next = ST_SUB;
                        end
                        default:
                        begin
                            dsh_next   = prod_reg << (QUO_W - 1);
                            quo_next   = '0;
                            dcnt_next  = DIV_STEPS;
                            state_next = ST_DIV;
                        end
                    endcase
                end
            end
            ST_SUB:
            begin
                // numerator clamps at zero
                rem_next    = borrow ? '0 : add_res[XW-1:0];
                prod_next   = '0;
                mcand_next  = XW'(count_reg);
                mplier_next = BW'(count_reg);
                state_next  = ST_NN;
            end
            ST_DIV:
            begin
                if (dcnt_reg != '0)
                begin
                    if (!borrow)
                    begin
                        rem_next = add_res[XW-1:0];
                    end
                    quo_next  = {quo_reg[QUO_W-2:0], ~borrow};
                    dsh_next  = dsh_reg >> 1;
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_data_next.window_variance = var_sat;
                    out_data_next.stable          = (var_sat < thr_reg);
                    out_data_next.sample_count    = CNT_OUT_W'(count_reg);
                    out_data_next.truncated       = ovf_reg;
                    out_valid_next                = 1'b1;
                    count_next                    = '0;
                    sum_next                      = '0;
                    sumsq_next                    = '0;
                    ovf_next                      = 1'b0;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            thr_reg       <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sumsq_reg     <= sumsq_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        prod_reg     <= prod_next;
        t_reg        <= t_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= WIN_MAX_C)
        else $error("window count beyond bound");

    a_sample_to_square: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (count_reg < WIN_MAX_C) |=> state_reg == ST_SQ)
        else $error("accumulated sample not squared");

    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (dcnt_reg == '0) && (!out_valid_reg || out_ready)
        |=> (count_reg == '0) && !ovf_reg && out_valid_reg)
        else $error("accumulators not cleared on result");

    a_result_from_divide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DIV))
        else $error("result raised outside divide");

endmodule
